// ===== hw/rtl/aisenc_pkg.sv =====
// ----------------------------------------------------------------------------
// aisenc_pkg
// types, constants and per-stage field conversion for the position report
// encoder pipeline
// ----------------------------------------------------------------------------
package aisenc_pkg;

   // payload layout
   localparam int unsigned PayloadBits = 168;
   localparam int unsigned GroupBits   = 6;
   localparam int unsigned NumGroups   = PayloadBits / GroupBits;
   localparam int unsigned CountBits   = $clog2(NumGroups);

   // small field limits and not-available codes
   localparam logic [7:0]  MaxSmallCode = 8'd3;
   localparam logic [5:0]  MsgDefault   = 6'd1;
   localparam logic [31:0] MmsiLimit    = 32'd999999999;
   localparam logic [7:0]  NavLimit     = 8'd15;
   localparam logic [3:0]  NavNa        = 4'd15;
   localparam logic [7:0]  UtcMax       = 8'd63;
   localparam logic [5:0]  UtcNa        = 6'd60;

   // rate of turn: |a| * DEGQ * 60 split into two 20-bit halves of the constant
   localparam logic [19:0] RotKHi = 20'd880063;
   localparam logic [19:0] RotKLo = 20'd181712;
   localparam logic [7:0]  RotNa  = 8'd128;

   // speed: ten times knots, divided by 2*463*65536 as >>16 then /926
   localparam logic [13:0] SogMul   = 14'd9000;
   localparam logic [34:0] SogLimit = 35'd31041060864;
   localparam logic [24:0] SogHalf  = 25'd30343168;
   localparam logic [20:0] SogRecip = 21'd1159549;
   localparam logic [9:0]  SogNa    = 10'd1023;

   // coordinates in 1/10000 minute
   localparam logic [19:0] CoordScale = 20'd600000;
   localparam logic [39:0] LonLimit   = 40'd3019898880;
   localparam logic [39:0] LatLimit   = 40'd1509949440;
   localparam logic [27:0] LonNa      = 28'd108600000;
   localparam logic [26:0] LatNa      = 27'd54600000;

   // course: angle * 10 * DEGQ, constant split at bit 19
   localparam logic [31:0] AngleLimit = 32'd117440512;
   localparam logic [18:0] CogKHi     = 19'd293354;
   localparam logic [18:0] CogKLo     = 19'd205048;
   localparam logic [11:0] CogNa      = 12'd3600;

   // heading: angle * DEGQ, constant split at bit 17
   localparam logic [16:0] HdgKHi = 17'd117341;
   localparam logic [16:0] HdgKLo = 17'd99148;
   localparam logic [8:0]  HdgMax = 9'd359;
   localparam logic [8:0]  HdgNa  = 9'd511;

   // armoring
   localparam logic [6:0] ArmorSplit = 7'd40;
   localparam logic [6:0] ArmorLow   = 7'd48;
   localparam logic [6:0] ArmorHigh  = 7'd56;

   typedef struct packed {
      logic [7:0]  message_type;
      logic [7:0]  repeat_count;
      logic [31:0] user_id;
      logic [7:0]  nav_status;
      logic [31:0] turn_rate;
      logic [31:0] speed;
      logic [1:0]  flags;
      logic [39:0] longitude;
      logic [39:0] latitude;
      logic [31:0] course;
      logic [31:0] heading;
      logic [7:0]  utc_seconds;
   } in_type;

   typedef struct packed {
      logic [5:0]  msg_type;
      logic [1:0]  repeat_ind;
      logic [29:0] mmsi;
      logic [3:0]  nav;
      logic        accuracy;
      logic        raim;
      logic [5:0]  utc;
   } head_type;

   typedef struct packed {
      head_type    head;
      logic        rot_neg;
      logic        rot_ok;
      logic [19:0] rot_mag;
      logic        spd_pos;
      logic [30:0] spd_val;
      logic        lon_neg;
      logic [39:0] lon_mag;
      logic        lat_neg;
      logic [39:0] lat_mag;
      logic        cog_ok;
      logic [26:0] cog_mag;
      logic        hdg_ok;
      logic [26:0] hdg_mag;
   } s1_type;

   typedef struct packed {
      head_type    head;
      logic        rot_neg;
      logic        rot_ok;
      logic [39:0] rot_pa;
      logic [39:0] rot_pb;
      logic        spd_pos;
      logic [44:0] spd_a;
      logic        lon_neg;
      logic        lon_ok;
      logic [51:0] lon_p;
      logic        lat_neg;
      logic        lat_ok;
      logic [51:0] lat_p;
      logic        cog_ok;
      logic [45:0] cog_ph;
      logic [45:0] cog_pl;
      logic        hdg_ok;
      logic [43:0] hdg_ph;
      logic [43:0] hdg_pl;
   } s2_type;

   typedef struct packed {
      head_type    head;
      logic        rot_neg;
      logic        rot_ok;
      logic [59:0] rot_p;
      logic        spd_ok;
      logic [19:0] spd_y;
      logic        lon_neg;
      logic        lon_ok;
      logic [26:0] lon_q;
      logic        lat_neg;
      logic        lat_ok;
      logic [26:0] lat_q;
      logic        cog_ok;
      logic [63:0] cog_q;
      logic        hdg_ok;
      logic [60:0] hdg_p;
   } s3_type;

   typedef struct packed {
      head_type    head;
      logic [7:0]  rot_code;
      logic        spd_ok;
      logic [40:0] spd_prod;
      logic [27:0] lon_code;
      logic [26:0] lat_code;
      logic [11:0] cog_code;
      logic [8:0]  hdg_code;
   } s4_type;

   // stage 1: small fields, magnitudes and signs
   function automatic s1_type stage1_f(in_type d);
      s1_type      s;
      logic [31:0] rmag;
      s.head.msg_type   = (d.message_type <= MaxSmallCode) ? d.message_type[5:0] : MsgDefault;
      s.head.repeat_ind = (d.repeat_count <= MaxSmallCode) ? d.repeat_count[1:0] : 2'd0;
      s.head.mmsi       = (d.user_id != 32'd0 && d.user_id < MmsiLimit) ?
                          d.user_id[29:0] : 30'd0;
      s.head.nav        = (d.nav_status < NavLimit) ? d.nav_status[3:0] : NavNa;
      s.head.accuracy   = d.flags[0];
      s.head.raim       = d.flags[1];
      s.head.utc        = (d.utc_seconds <= UtcMax) ? d.utc_seconds[5:0] : UtcNa;
      s.rot_neg = d.turn_rate[31];
      rmag      = s.rot_neg ? (~d.turn_rate + 32'd1) : d.turn_rate;
      s.rot_ok  = (rmag[31:20] == 12'd0);
      s.rot_mag = rmag[19:0];
      s.spd_pos = !d.speed[31];
      s.spd_val = d.speed[30:0];
      s.lon_neg = d.longitude[39];
      s.lon_mag = s.lon_neg ? (~d.longitude + 40'd1) : d.longitude;
      s.lat_neg = d.latitude[39];
      s.lat_mag = s.lat_neg ? (~d.latitude + 40'd1) : d.latitude;
      s.cog_ok  = !d.course[31] && (d.course < AngleLimit);
      s.cog_mag = d.course[26:0];
      s.hdg_ok  = !d.heading[31] && (d.heading < AngleLimit);
      s.hdg_mag = d.heading[26:0];
      return s;
   endfunction

   // stage 2: constant multiplies and coordinate range checks
   function automatic s2_type stage2_f(s1_type s);
      s2_type t;
      t.head    = s.head;
      t.rot_neg = s.rot_neg;
      t.rot_ok  = s.rot_ok;
      t.rot_pa  = 40'(s.rot_mag) * 40'(RotKHi);
      t.rot_pb  = 40'(s.rot_mag) * 40'(RotKLo);
      t.spd_pos = s.spd_pos;
      t.spd_a   = 45'(s.spd_val) * 45'(SogMul);
      t.lon_neg = s.lon_neg;
      t.lon_ok  = (s.lon_mag <= LonLimit);
      t.lon_p   = 52'(s.lon_mag[31:0]) * 52'(CoordScale);
      t.lat_neg = s.lat_neg;
      t.lat_ok  = (s.lat_mag <= LatLimit);
      t.lat_p   = 52'(s.lat_mag[31:0]) * 52'(CoordScale);
      t.cog_ok  = s.cog_ok;
      t.cog_ph  = 46'(s.cog_mag) * 46'(CogKHi);
      t.cog_pl  = 46'(s.cog_mag) * 46'(CogKLo);
      t.hdg_ok  = s.hdg_ok;
      t.hdg_ph  = 44'(s.hdg_mag) * 44'(HdgKHi);
      t.hdg_pl  = 44'(s.hdg_mag) * 44'(HdgKLo);
      return t;
   endfunction

   // stage 3: combine partial products, speed range check and prescale
   function automatic s3_type stage3_f(s2_type s);
      s3_type      t;
      logic [45:0] spd_sum;
      logic [64:0] cog_sum;
      t.head    = s.head;
      t.rot_neg = s.rot_neg;
      t.rot_ok  = s.rot_ok;
      t.rot_p   = {s.rot_pa, 20'd0} + {20'd0, s.rot_pb};
      t.spd_ok  = s.spd_pos && (s.spd_a < 45'(SogLimit));
      spd_sum   = {s.spd_a, 1'b0} + 46'(SogHalf);
      t.spd_y   = spd_sum[35:16];
      t.lon_neg = s.lon_neg;
      t.lon_ok  = s.lon_ok;
      t.lon_q   = s.lon_p[50:24];
      t.lat_neg = s.lat_neg;
      t.lat_ok  = s.lat_ok;
      t.lat_q   = s.lat_p[50:24];
      t.cog_ok  = s.cog_ok;
      cog_sum   = {s.cog_ph, 19'd0} + {19'd0, s.cog_pl};
      t.cog_q   = cog_sum[63:0];
      t.hdg_ok  = s.hdg_ok;
      t.hdg_p   = {s.hdg_ph, 17'd0} + {17'd0, s.hdg_pl};
      return t;
   endfunction

   // stage 4: rounding, signs and not-available selection; speed reciprocal
   function automatic s4_type stage4_f(s3_type s);
      s4_type     t;
      logic [7:0] rot_n;
      logic [8:0] hdg_hi;
      logic       hdg_in;
      t.head = s.head;
      rot_n  = {1'b0, s.rot_p[58:52]} + {7'd0, s.rot_p[51]};
      if (s.rot_ok && !s.rot_p[59]) begin
         t.rot_code = s.rot_neg ? (~rot_n + 8'd1) : rot_n;
      end else begin
         t.rot_code = RotNa;
      end
      t.spd_ok   = s.spd_ok;
      t.spd_prod = 41'(s.spd_y) * 41'(SogRecip);
      if (!s.lon_ok) begin
         t.lon_code = LonNa;
      end else begin
         t.lon_code = s.lon_neg ? (~{1'b0, s.lon_q} + 28'd1) : {1'b0, s.lon_q};
      end
      if (!s.lat_ok) begin
         t.lat_code = LatNa;
      end else begin
         t.lat_code = s.lat_neg ? (~s.lat_q + 27'd1) : s.lat_q;
      end
      if (s.cog_ok && (s.cog_q[63:52] < CogNa)) begin
         t.cog_code = s.cog_q[63:52] + {11'd0, s.cog_q[51]};
      end else begin
         t.cog_code = CogNa;
      end
      hdg_hi = s.hdg_p[60:52];
      hdg_in = (hdg_hi < HdgMax) || ((hdg_hi == HdgMax) && (s.hdg_p[51:0] == 52'd0));
      t.hdg_code = (s.hdg_ok && hdg_in) ? (hdg_hi + {8'd0, s.hdg_p[51]}) : HdgNa;
      return t;
   endfunction

   // stage 5: speed quotient and bit packing, MSB first
   function automatic logic [PayloadBits-1:0] stage5_f(s4_type s);
      logic [9:0] sog;
      sog = s.spd_ok ? s.spd_prod[39:30] : SogNa;
      return {s.head.msg_type, s.head.repeat_ind, s.head.mmsi, s.head.nav,
              s.rot_code, sog, s.head.accuracy, s.lon_code, s.lat_code,
              s.cog_code, s.hdg_code, s.head.utc, 2'd0, 3'd0, s.head.raim, 19'd0};
   endfunction

   function automatic logic [6:0] armor_f(logic [GroupBits-1:0] grp);
      logic [6:0] g;
      g = {1'b0, grp};
      return (g < ArmorSplit) ? (g + ArmorLow) : (g + ArmorHigh);
   endfunction

endpackage

// ===== hw/rtl/aisenc_req_if.sv =====
// ----------------------------------------------------------------------------
// aisenc_req_if
// request channel: one fixed-point position report per beat
// ----------------------------------------------------------------------------
interface aisenc_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         message_type;
   logic [7:0]         repeat_count;
   logic [31:0]        user_id;
   logic [7:0]         nav_status;
   logic signed [31:0] turn_rate;
   logic signed [31:0] speed;
   logic [1:0]         flags;
   logic signed [39:0] longitude;
   logic signed [39:0] latitude;
   logic signed [31:0] course;
   logic signed [31:0] heading;
   logic [7:0]         utc_seconds;

   modport source (
      output valid, message_type, repeat_count, user_id, nav_status, turn_rate,
             speed, flags, longitude, latitude, course, heading, utc_seconds,
      input  ready
   );

   modport sink (
      input  valid, message_type, repeat_count, user_id, nav_status, turn_rate,
             speed, flags, longitude, latitude, course, heading, utc_seconds,
      output ready
   );
endinterface

// ===== hw/rtl/aisenc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// aisenc_rsp_if
// response channel: one armored payload character per beat
// ----------------------------------------------------------------------------
interface aisenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] armored_char;
   logic       last_char;

   modport source (
      output valid, armored_char, last_char,
      input  ready
   );

   modport sink (
      input  valid, armored_char, last_char,
      output ready
   );
endinterface

// ===== hw/rtl/ais_position_report_encoder.sv =====
// ----------------------------------------------------------------------------
// ais_position_report_encoder
// fixed-point position report to 28 armored characters of a type 1 payload
// ----------------------------------------------------------------------------
// usage:
//  - req_ch carries one position report per beat (valid/ready); rsp_ch returns
//    the 168-bit payload as 28 armored six-bit characters, MSB first, with
//    last_char set on the 28th beat
//  - five pipeline stages convert the fields (magnitudes, constant multiplies,
//    partial product sums, rounding and code selection, packing); a shift
//    register then sends one character per cycle while the receiver is ready
//  - with the pipe empty, a request runs through every stage and is then loaded
//    into the shift register, whose top group is the first character sent
//  - the report rate is set by the character output; the next report loads
//    into the shift register in the same cycle the last character is taken,
//    so bursts run without gaps
//  - up to five further reports are accepted while one is being sent
//  - a stalled receiver holds the current character; the stages behind it
//    fill and then hold, and req_ch.ready drops once stage one is occupied
//  - reset clears all valid bits and the character counter; data registers
//    are not reset
// ----------------------------------------------------------------------------
module ais_position_report_encoder (
   input  logic         clock,
   input  logic         reset,
   aisenc_req_if.sink   req_ch,
   aisenc_rsp_if.source rsp_ch
);

   localparam int unsigned PBits = aisenc_pkg::PayloadBits;
   localparam int unsigned GBits = aisenc_pkg::GroupBits;
   localparam int unsigned CBits = aisenc_pkg::CountBits;
   localparam logic [CBits-1:0] LastGroup = CBits'(aisenc_pkg::NumGroups - 1);

   aisenc_pkg::in_type req_data;

   // pipeline registers
   aisenc_pkg::s1_type s1_ff, s1_in;
   aisenc_pkg::s2_type s2_ff, s2_in;
   aisenc_pkg::s3_type s3_ff, s3_in;
   aisenc_pkg::s4_type s4_ff, s4_in;
   logic [PBits-1:0]   s5_ff, s5_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s5_valid_ff, s5_valid_in;

   // output shift register
   logic [PBits-1:0] ser_data_ff, ser_data_in;
   logic [CBits-1:0] ser_count_ff, ser_count_in;
   logic             ser_valid_ff, ser_valid_in;

   logic en1, en2, en3, en4, en5;
   logic rsp_beat, rsp_last, load_ser;

   assign req_data = '{
      message_type: req_ch.message_type,
      repeat_count: req_ch.repeat_count,
      user_id:      req_ch.user_id,
      nav_status:   req_ch.nav_status,
      turn_rate:    req_ch.turn_rate,
      speed:        req_ch.speed,
      flags:        req_ch.flags,
      longitude:    req_ch.longitude,
      latitude:     req_ch.latitude,
      course:       req_ch.course,
      heading:      req_ch.heading,
      utc_seconds:  req_ch.utc_seconds
   };

   // response side
   assign rsp_last            = (ser_count_ff == LastGroup);
   assign rsp_beat            = ser_valid_ff && rsp_ch.ready;
   assign rsp_ch.valid        = ser_valid_ff;
   assign rsp_ch.armored_char = aisenc_pkg::armor_f(ser_data_ff[PBits-1 -: GBits]);
   assign rsp_ch.last_char    = rsp_last;

   // shift register takes a new payload when empty or on the final beat
   assign load_ser = !ser_valid_ff || (rsp_ch.ready && rsp_last);

   // a stage loads when it is empty or its contents move on
   assign en5 = !s5_valid_ff || load_ser;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ch.ready = en1;

   always_comb begin
      s1_valid_in = en1 ? req_ch.valid : s1_valid_ff;
      s1_in       = en1 ? aisenc_pkg::stage1_f(req_data) : s1_ff;
      s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
      s2_in       = en2 ? aisenc_pkg::stage2_f(s1_ff) : s2_ff;
      s3_valid_in = en3 ? s2_valid_ff : s3_valid_ff;
      s3_in       = en3 ? aisenc_pkg::stage3_f(s2_ff) : s3_ff;
      s4_valid_in = en4 ? s3_valid_ff : s4_valid_ff;
      s4_in       = en4 ? aisenc_pkg::stage4_f(s3_ff) : s4_ff;
      s5_valid_in = en5 ? s4_valid_ff : s5_valid_ff;
      s5_in       = en5 ? aisenc_pkg::stage5_f(s4_ff) : s5_ff;
   end

   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_data_in  = ser_data_ff;
      ser_count_in = ser_count_ff;
      if (load_ser) begin
         ser_valid_in = s5_valid_ff;
         ser_data_in  = s5_ff;
         ser_count_in = '0;
      end else if (rsp_ch.ready) begin
         // next group moves to the top
         ser_data_in  = {ser_data_ff[PBits-GBits-1:0], GBits'(0)};
         ser_count_in = ser_count_ff + CBits'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         ser_valid_ff <= 1'b0;
         ser_count_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         ser_valid_ff <= ser_valid_in;
         ser_count_ff <= ser_count_in;
      end
   end

   // data path, no reset
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      s4_ff       <= s4_in;
      s5_ff       <= s5_in;
      ser_data_ff <= ser_data_in;
   end

   // a finished payload waiting for the shift register is held unchanged
   a_s5_hold: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && !load_ser) |=> (s5_valid_ff && $stable(s5_ff)))
      else $error("waiting payload lost or changed");

   // a report is sent without a hole: every non-final beat is followed by the next
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_last) |=>
         (ser_valid_ff && (ser_count_ff == $past(ser_count_ff) + CBits'(1))))
      else $error("character sequence broken");

   // after the final beat the counter starts over
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_last) |=> (ser_count_ff == '0))
      else $error("counter not restarted after last character");

   // an empty first stage always takes a request
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("request refused with empty first stage");

endmodule
